FILE: rtl/bac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bac_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int MIN_DIM     = 3;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int DIM_W       = 12;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0]       THRESHOLD_RESET = 8'd128;
	localparam logic [DIM_W-1:0] WIDTH_RESET     = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET    = 12'd480;

	typedef enum logic [1:0] {
		REG_THRESHOLD    = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2,
		REG_UNUSED       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [10:0] row;
		logic [10:0] column;
		logic        contour;
		logic        frame_done;
	} result_t;

	// Pixel after thresholding, with its raster position.
	typedef struct packed {
		logic             valid;
		logic             white;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} stage_t;

	// Last column and last row of the clamped frame geometry.
	typedef struct packed {
		logic [COL_W-1:0] last_col;
		logic [ROW_W-1:0] last_row;
	} geom_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_W'(MIN_DIM))
			r = DIM_W'(MIN_DIM);
		else if (v > maxv)
			r = maxv;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bac_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
module bac_line_store import bac_pkg::*; (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [COL_W-1:0] rd_addr,
	output logic      [1:0]       rd_data,
	input  wire logic             wr_en,
	input  wire logic [COL_W-1:0] wr_addr,
	input  wire logic [1:0]       wr_data
);

	// Each entry holds {upper line bit, middle line bit} for one column.
	logic [1:0] mem [MAX_WIDTH];
	logic [1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/bac_window.sv
`timescale 1ns / 1ps
`default_nettype none
module bac_window import bac_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire stage_t  stage_s1,
	input  wire logic    up,
	input  wire logic    mid,
	input  wire geom_t   geom,
	output logic         push,
	output result_t      push_data
);

	// Columns of the window: bits 0..2 left, 3..5 centre, 6..8 right.
	logic [8:0] window_q;
	logic [8:0] window_next;
	logic [2:0] new_col;
	logic       centre;
	logic       interior;

	assign new_col     = {stage_s1.white, mid, up};
	assign window_next = {new_col, window_q[8:3]};
	assign centre      = window_next[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (stage_s1.valid) begin
			window_q <= window_next;
		end
	end

	assign interior = (stage_s1.row >= ROW_W'(2)) && (stage_s1.col >= COL_W'(2))
		&& (stage_s1.row <= geom.last_row) && (stage_s1.col <= geom.last_col);

	assign push = stage_s1.valid && interior;

	always_comb begin
		push_data.row        = stage_s1.row - ROW_W'(1);
		push_data.column     = stage_s1.col - COL_W'(1);
		push_data.contour    = !centre && ((window_next & 9'h1EF) != 9'd0);
		push_data.frame_done = (stage_s1.row == geom.last_row)
			&& (stage_s1.col == geom.last_col);
	end

endmodule
`default_nettype wire

FILE: rtl/bac_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module bac_res_fifo import bac_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire result_t               push_data,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output result_t                    res,
	output logic      [FIFO_CNT_W-1:0] level
);

	result_t               slots [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign res_valid = (count_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res       = slots[rd_ptr_q];
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/binarize_and_contour_3x3.sv
// Each accepted pixel is registered in stage_s1; any result is then queued.
// Throughput: one pixel per cycle while pix_stall is low; line store: one read
// and one write per cycle; a four-entry result queue absorbs output stalls.
// Reset: asynchronous, active low; clears counters, window, queue and
// restores threshold 128, width 640, height 480. Line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module binarize_and_contour_3x3 import bac_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       pix_valid,
	output logic            pix_stall,
	input  wire pixel_t     pix,
	output logic            res_valid,
	input  wire logic       res_stall,
	output result_t         res,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire cfg_reg_t   cfg_index,
	input  wire logic [11:0] cfg_data
);

	logic [7:0]       threshold_q;
	geom_t            geom_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	stage_t           stage_s1;
	logic             accept;
	logic             white;
	logic [1:0]       line_rd;
	logic             push;
	result_t          push_data;
	logic [FIFO_CNT_W-1:0] level;
	logic [DIM_W-1:0] dim_clamped;

	assign cfg_ready = 1'b1;

	// A pixel is taken only when the queue has room for it and the one in flight.
	assign pix_stall = ((level + FIFO_CNT_W'(stage_s1.valid)) > FIFO_CNT_W'(FIFO_DEPTH - 1));
	assign accept    = pix_valid && !pix_stall;

	assign white = (pix.red > threshold_q) || (pix.green > threshold_q)
		|| (pix.blue > threshold_q);

	always_comb begin
		unique case (cfg_index)
			REG_FRAME_HEIGHT: dim_clamped = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
			default:          dim_clamped = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q     <= THRESHOLD_RESET;
			geom_q.last_col <= COL_W'(WIDTH_RESET - DIM_W'(1));
			geom_q.last_row <= ROW_W'(HEIGHT_RESET - DIM_W'(1));
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD:    threshold_q     <= cfg_data[7:0];
				REG_FRAME_WIDTH:  geom_q.last_col <= COL_W'(dim_clamped - DIM_W'(1));
				REG_FRAME_HEIGHT: geom_q.last_row <= ROW_W'(dim_clamped - DIM_W'(1));
				REG_UNUSED:       ;
			endcase
		end
	end

	// Raster position of the next incoming pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q >= geom_q.last_col) begin
				col_q <= '0;
				row_q <= (row_q >= geom_q.last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1.valid <= accept;
			if (accept) begin
				stage_s1.white <= white;
				stage_s1.col   <= col_q;
				stage_s1.row   <= row_q;
			end
		end
	end

	// The same column comes back at least three beats later, after its write.
	bac_line_store u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (line_rd),
		.wr_en   (stage_s1.valid),
		.wr_addr (stage_s1.col),
		.wr_data ({line_rd[0], stage_s1.white})
	);

	bac_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage_s1  (stage_s1),
		.up        (line_rd[1]),
		.mid       (line_rd[0]),
		.geom      (geom_q),
		.push      (push),
		.push_data (push_data)
	);

	bac_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.level     (level)
	);

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import bac_pkg::*;

	typedef enum int {
		STYLE_NOISE,
		STYLE_NEAR_THRESHOLD,
		STYLE_SPARSE_WHITE,
		STYLE_DENSE_WHITE
	} pixel_style_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         pix_valid;
	logic         pix_stall;
	pixel_t       pix;
	logic         res_valid;
	logic         res_stall;
	result_t      res;
	logic         cfg_valid;
	logic         cfg_ready;
	cfg_reg_t     cfg_index;
	logic [11:0]  cfg_data;

	// Shadow of the block: settings, line stores, window and raster position.
	logic [7:0]   thr_q;
	logic [11:0]  width_q;
	logic [11:0]  height_q;
	logic         upper_bits [MAX_WIDTH];
	logic         middle_bits [MAX_WIDTH];
	logic [8:0]   window_q;
	int           col_q;
	int           row_q;
	int           seen_cols;
	int           filled_cols;

	result_t      expected_results [$];
	pixel_t       pending_pixels [$];
	result_t      oldest_expected;

	int           failures;
	int           pixels_in;
	int           results_seen;
	int           contours_seen;
	int           reg_writes;
	int           gap_left;
	int           stall_left;
	int           idle_len;
	bit           steady;
	bit           long_hold_req;
	bit           long_hold_done;

	binarize_and_contour_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clamp_size(input logic [11:0] v, input int maxv);
		if (v < 3)
			return 3;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Number of pixel beats until the raster position is back at the frame origin.
	function automatic int pixels_to_frame_end();
		int c, r, w, h, n;
		c = col_q;
		r = row_q;
		w = clamp_size(width_q, MAX_WIDTH);
		h = clamp_size(height_q, MAX_HEIGHT);
		n = 0;
		while (c != 0 || r != 0) begin
			n++;
			if (c >= w - 1) begin
				c = 0;
				r = (r >= h - 1) ? 0 : r + 1;
			end else begin
				c++;
			end
		end
		return n;
	endfunction

	function automatic logic [7:0] near_level();
		case ($urandom_range(0, 4))
			0: return (thr_q == 8'd0) ? 8'd0 : thr_q - 8'd1;
			1: return thr_q;
			2: return (thr_q == 8'd255) ? 8'd255 : thr_q + 8'd1;
			3: return 8'd0;
			default: return 8'd255;
		endcase
	endfunction

	function automatic pixel_t make_pixel(input pixel_style_t style);
		pixel_t p;
		logic [7:0] lit;
		int k;
		case (style)
			STYLE_NOISE: begin
				{p.red, p.green, p.blue} = 24'($urandom);
			end
			STYLE_NEAR_THRESHOLD: begin
				p.red = near_level();
				p.green = near_level();
				p.blue = near_level();
			end
			default: begin
				p.red = 8'($urandom_range(0, thr_q));
				p.green = 8'($urandom_range(0, thr_q));
				p.blue = 8'($urandom_range(0, thr_q));
				k = (style == STYLE_SPARSE_WHITE) ? 2 : 8;
				if (thr_q != 8'd255 && $urandom_range(0, 9) < k) begin
					lit = 8'($urandom_range(thr_q + 1, 255));
					case ($urandom_range(0, 2))
						0: p.red = lit;
						1: p.green = lit;
						default: p.blue = lit;
					endcase
				end
			end
		endcase
		return p;
	endfunction

	task automatic queue_pixel(input pixel_t p);
		pending_pixels.insert(pending_pixels.size(), p);
	endtask

	// Threshold one pixel, shift it into the window and queue the interior result.
	task automatic predict_contour(input pixel_t p);
		int w, h;
		logic white, up, mid;
		logic [8:0] others;
		result_t e;
		w = clamp_size(width_q, MAX_WIDTH);
		h = clamp_size(height_q, MAX_HEIGHT);
		white = (p.red > thr_q) || (p.green > thr_q) || (p.blue > thr_q);
		up = 1'b0;
		mid = 1'b0;
		if (col_q < MAX_WIDTH) begin
			up = upper_bits[col_q];
			mid = middle_bits[col_q];
			upper_bits[col_q] = mid;
			middle_bits[col_q] = white;
			// The upper bit of a column only holds a real pixel from its second write on.
			if (col_q < seen_cols && col_q + 1 > filled_cols)
				filled_cols = col_q + 1;
			if (col_q + 1 > seen_cols)
				seen_cols = col_q + 1;
		end
		// Window columns shift left; the new column carries bottom, middle, top.
		window_q = {white, mid, up, window_q[8:3]};
		if (row_q >= 2 && col_q >= 2 && row_q < h && col_q < w) begin
			others = window_q & 9'h1EF;
			e.row = 11'(row_q - 1);
			e.column = 11'(col_q - 1);
			e.contour = !window_q[4] && (others != 9'd0);
			e.frame_done = (row_q == h - 1) && (col_q == w - 1);
			expected_results.insert(expected_results.size(), e);
		end
		if (col_q >= w - 1) begin
			col_q = 0;
			row_q = (row_q >= h - 1) ? 0 : row_q + 1;
		end else begin
			col_q++;
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [11:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_q = data[7:0];
			REG_FRAME_WIDTH: width_q = data;
			REG_FRAME_HEIGHT: height_q = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	// Sampled on the falling edge so the driver's updates at the rising edge are settled.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || pix_valid || expected_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_frames(input int frames, input int extra, input pixel_style_t style,
			output int sent);
		sent = pixels_to_frame_end()
			+ frames * clamp_size(width_q, MAX_WIDTH) * clamp_size(height_q, MAX_HEIGHT)
			+ extra;
		repeat (sent) queue_pixel(make_pixel(style));
	endtask

	// Pixel driver: a stalled beat is held until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix <= '0;
			gap_left <= 0;
		end else begin
			if (pix_valid && !pix_stall) begin
				predict_contour(pix);
				pixels_in++;
			end
			if (!(pix_valid && pix_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					pix_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					pix <= pending_pixels.pop_front();
					pix_valid <= 1'b1;
					gap_left <= steady ? 0 : pick_idle();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure, with one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (long_hold_req && !long_hold_done) begin
			res_stall <= 1'b1;
			stall_left <= 300;
			long_hold_done <= 1'b1;
		end else begin
			idle_len = steady ? 0 : pick_idle();
			res_stall <= (idle_len != 0);
			stall_left <= (idle_len > 0) ? idle_len - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (res.contour)
				contours_seen++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: row %0d column %0d", res.row, res.column);
				failures++;
			end else begin
				oldest_expected = expected_results.pop_front();
				if (res.row !== oldest_expected.row) begin
					$error("row: expected %0d, got %0d", oldest_expected.row, res.row);
					failures++;
				end
				if (res.column !== oldest_expected.column) begin
					$error("column: expected %0d, got %0d", oldest_expected.column, res.column);
					failures++;
				end
				if (res.contour !== oldest_expected.contour) begin
					$error("contour: expected %0d, got %0d", oldest_expected.contour,
						res.contour);
					failures++;
				end
				if (res.frame_done !== oldest_expected.frame_done) begin
					$error("frame_done: expected %0d, got %0d", oldest_expected.frame_done,
						res.frame_done);
					failures++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int sent;
		int random_total;
		int w, h, tdata;
		logic [11:0] wd, hd;
		pixel_style_t style;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		steady = 1'b0;
		long_hold_req = 1'b0;
		failures = 0;
		pixels_in = 0;
		results_seen = 0;
		contours_seen = 0;
		reg_writes = 0;
		random_total = 0;
		thr_q = THRESHOLD_RESET;
		width_q = WIDTH_RESET;
		height_q = HEIGHT_RESET;
		window_q = '0;
		col_q = 0;
		row_q = 0;
		seen_cols = 0;
		filled_cols = 0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_bits[i] = 1'b0;
			middle_bits[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest frames. Sizes below three act as three; a channel equal to the
		// threshold is still black.
		write_reg(REG_THRESHOLD, 12'h080);
		write_reg(REG_FRAME_WIDTH, 12'd0);
		write_reg(REG_FRAME_HEIGHT, 12'd2);
		queue_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
		queue_pixel(pixel_t'{8'd0, 8'd0, 8'd0});
		queue_pixel(pixel_t'{8'd128, 8'd128, 8'd128});
		queue_pixel(pixel_t'{8'd0, 8'd0, 8'd0});
		queue_pixel(pixel_t'{8'd128, 8'd128, 8'd128});
		queue_pixel(pixel_t'{8'd0, 8'd129, 8'd0});
		queue_pixel(pixel_t'{8'd0, 8'd0, 8'd129});
		queue_pixel(pixel_t'{8'd128, 8'd0, 8'd0});
		queue_pixel(pixel_t'{8'd0, 8'd128, 8'd0});
		repeat (9) queue_pixel(pixel_t'{8'd128, 8'd0, 8'd128});
		for (int k = 0; k < 9; k++)
			queue_pixel((k % 2 == 1) ? pixel_t'{8'd0, 8'd0, 8'd0}
				: pixel_t'{8'd129, 8'd129, 8'd129});
		wait_idle();

		// Hold off the result side while pixels keep coming, so the block fills up.
		write_reg(REG_FRAME_WIDTH, 12'd12);
		write_reg(REG_FRAME_HEIGHT, 12'd10);
		steady = 1'b1;
		long_hold_req = 1'b1;
		send_frames(1, 0, STYLE_NOISE, sent);
		random_total += sent;
		wait_idle();

		while (random_total < 1050) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 5))
					0: tdata = 0;
					1: tdata = 255;
					default: tdata = $urandom_range(0, 255);
				endcase
				write_reg(REG_THRESHOLD, {4'($urandom), 8'(tdata)});
			end
			if ($urandom_range(0, 9) < 7) begin
				wd = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
					: 12'($urandom_range(3, 14));
				// Mid-frame, never widen past columns whose line bits are both written.
				if ((col_q != 0 || row_q != 0) && clamp_size(wd, MAX_WIDTH) > filled_cols)
					wd = 12'(filled_cols);
				write_reg(REG_FRAME_WIDTH, wd);
			end
			if ($urandom_range(0, 9) < 6) begin
				hd = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
					: 12'($urandom_range(3, 8));
				write_reg(REG_FRAME_HEIGHT, hd);
			end
			if ($urandom_range(0, 11) == 0)
				write_reg(REG_UNUSED, 12'($urandom));
			style = pixel_style_t'($urandom_range(0, 3));
			w = clamp_size(width_q, MAX_WIDTH);
			h = clamp_size(height_q, MAX_HEIGHT);
			// Some phases stop inside a frame, so the next settings land mid-frame.
			if ($urandom_range(0, 5) == 0)
				send_frames(0, $urandom_range(1, w * h - 1), style, sent);
			else
				send_frames($urandom_range(1, 3), 0, style, sent);
			random_total += sent;
			wait_idle();
		end

		// Finish any open frame before the largest sizes, which are clamped.
		send_frames(0, 0, STYLE_NOISE, sent);
		wait_idle();
		steady = 1'b1;
		write_reg(REG_THRESHOLD, 12'h07F);
		write_reg(REG_FRAME_WIDTH, 12'hFFF);
		write_reg(REG_FRAME_HEIGHT, 12'd1);
		send_frames(0, 64, STYLE_SPARSE_WHITE, sent);
		wait_idle();
		// Narrowing inside the first row wraps the column; the tall height is clamped.
		write_reg(REG_FRAME_WIDTH, 12'd2);
		write_reg(REG_FRAME_HEIGHT, 12'd2049);
		repeat (60) queue_pixel(make_pixel(STYLE_DENSE_WHITE));
		wait_idle();
		repeat (16) @(posedge clk);

		$display("Run covered %0d pixel beats and %0d register writes.", pixels_in, reg_writes);
		$display("Checked %0d results, %0d of them on a contour.", results_seen, contours_seen);
		if (failures == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
